// ===== sv/ldef_pkg.sv =====
// ----------------------------------------------------------------------------
// ldef_pkg
// Shared types and constants of the duplicate event filter.
// ----------------------------------------------------------------------------
package ldef_pkg;

  localparam int CacheEntries = 4;
  localparam int ProcW        = 32;
  localparam int SeqW         = 32;
  localparam int CapW         = 6;
  localparam int AddrW        = 3;
  localparam int DataW        = 32;

  // register indexes
  localparam logic [0:0] RegFilterEn = 1'b0;
  localparam logic [0:0] RegLogEn    = 1'b1;

  typedef struct packed {
    logic             cred_present;
    logic [ProcW-1:0] process_id;
    logic [SeqW-1:0]  seq_tag;
    logic [CapW-1:0]  cap_number;
  } ldef_req_t;

  typedef struct packed {
    logic emit_log;
    logic was_hit;
  } ldef_rsp_t;

  typedef struct packed {
    logic [ProcW-1:0] process_id;
    logic [SeqW-1:0]  seq_tag;
    logic [CapW-1:0]  cap_number;
  } ldef_key_t;

  typedef struct packed {
    logic filter_en;
    logic log_en;
  } ldef_cfg_t;

endpackage

// ===== sv/ldef_cell.sv =====
// ----------------------------------------------------------------------------
// ldef_cell
// One slot of the recency chain: holds a key, compares it against the probe
// and takes its upper neighbor's key when an update passes through it.
// ----------------------------------------------------------------------------
module ldef_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              update_i,
  input  ldef_pkg::ldef_key_t probe_i,
  input  ldef_pkg::ldef_key_t prev_key_i,
  input  logic              hit_above_i,
  output ldef_pkg::ldef_key_t key_o,
  output logic              hit_above_o
);
  import ldef_pkg::*;

  ldef_key_t key_q, key_d;
  logic      match;

  assign match       = (key_q == probe_i);
  assign hit_above_o = hit_above_i | match;
  assign key_o       = key_q;

  // shift only while no more recent slot matched; the matching slot itself
  // takes its neighbor's key since the probe moves to the head
  always_comb begin
    key_d = key_q;
    if (update_i && !hit_above_i) begin
      key_d = prev_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

endmodule

// ===== sv/ldef_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ldef_cfg_regs
// APB register file: filter enable and log enable.
// ----------------------------------------------------------------------------
module ldef_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ldef_pkg::AddrW-1:0] paddr,
  input  logic [ldef_pkg::DataW-1:0] pwdata,
  output logic [ldef_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output ldef_pkg::ldef_cfg_t        cfg_o
);
  import ldef_pkg::*;

  ldef_cfg_t  cfg_q, cfg_d;
  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegFilterEn: cfg_d.filter_en = pwdata[0];
        RegLogEn:    cfg_d.log_en    = pwdata[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegFilterEn: prdata = {{(DataW-1){1'b0}}, cfg_q.filter_en};
      RegLogEn:    prdata = {{(DataW-1){1'b0}}, cfg_q.log_en};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{filter_en: 1'b1, log_en: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/lru_duplicate_event_filter.sv =====
// ----------------------------------------------------------------------------
// lru_duplicate_event_filter
// Suppresses repeated denial events with a small LRU store of recent keys.
// ----------------------------------------------------------------------------
// port group   direction  signals
// command      in/out     start_i, busy_o, req_i (ldef_req_t)
// result       out        done_o, rsp_o (ldef_rsp_t)
// config       in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One event per clock; the result is registered from the single combinational
// pass of the probe through the cell chain.
// The store is a move-to-front chain: cell 0 is most recent, the last cell is
// the victim. Reset clears all keys to zero and both enables to one.
// busy_o stays low; results are shown for one cycle with done_o and cannot
// be stalled.
// ----------------------------------------------------------------------------
module lru_duplicate_event_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  ldef_pkg::ldef_req_t        req_i,
  output logic                       done_o,
  output ldef_pkg::ldef_rsp_t        rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ldef_pkg::AddrW-1:0] paddr,
  input  logic [ldef_pkg::DataW-1:0] pwdata,
  output logic [ldef_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import ldef_pkg::*;

  ldef_cfg_t cfg;
  ldef_key_t probe;
  ldef_key_t key_c [CacheEntries+1];
  logic      hit_c [CacheEntries+1];
  logic      accept, lookup, update, hit;
  logic      done_q, done_d;
  ldef_rsp_t rsp_q, rsp_d;

  ldef_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign lookup = accept & req_i.cred_present & cfg.filter_en;
  assign update = lookup;

  assign probe = '{process_id: req_i.process_id,
                   seq_tag:    req_i.seq_tag,
                   cap_number: req_i.cap_number};

  // cell 0 takes the probe; hit ripples toward the tail
  assign key_c[0] = probe;
  assign hit_c[0] = 1'b0;

  for (genvar g = 0; g < CacheEntries; g++) begin : g_cell
    ldef_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .update_i    (update),
      .probe_i     (probe),
      .prev_key_i  (key_c[g]),
      .hit_above_i (hit_c[g]),
      .key_o       (key_c[g+1]),
      .hit_above_o (hit_c[g+1])
    );
  end

  assign hit = hit_c[CacheEntries];

  always_comb begin
    done_d        = accept;
    rsp_d.was_hit = lookup & hit;
    rsp_d.emit_log = accept & req_i.cred_present & cfg.log_en &
                     (~cfg.filter_en | ~hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/ldef_checker.sv =====
// ----------------------------------------------------------------------------
// ldef_checker
// Port-level checks of the duplicate event filter, bound to the top level.
// ----------------------------------------------------------------------------
module ldef_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input ldef_pkg::ldef_req_t req_i,
  input logic                done_o,
  input ldef_pkg::ldef_rsp_t rsp_o
);
  import ldef_pkg::*;

  // every accepted word gives its result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("result missing after accepted word");

  // no result without a word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without accepted word");

  // an event without credential is dropped silently
  a_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !req_i.cred_present) |=>
      (!rsp_o.emit_log && !rsp_o.was_hit))
    else $error("absent credential produced a result flag");

  // a suppressed duplicate is never logged
  a_hit_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.was_hit) |-> !rsp_o.emit_log)
    else $error("hit was logged");

endmodule

bind lru_duplicate_event_filter ldef_checker u_ldef_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
